>>> src/fpa_pkg.sv
// Shared types, widths and codes for the four-lane priority arbiter.
// No dependencies; every other file of the block but fpa_ram uses this package.
`default_nettype none

package fpa_pkg;

   localparam int NUM_LANES   = 4;
   localparam int LANE_W      = 2;
   localparam int QUEUE_DEPTH = 1024;
   localparam int HEAD_W      = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 32;
   localparam int TIME_W      = 32;
   localparam int SIZE_THR_W  = 11;
   localparam int WAIT_THR_W  = 32;
   localparam int CMP_W       = (COUNT_W > SIZE_THR_W) ? COUNT_W : SIZE_THR_W;
   localparam int PICK_W      = (TIME_W > COUNT_W) ? TIME_W : COUNT_W;
   localparam int ADDR_W      = HEAD_W + LANE_W;
   localparam int RAM_DEPTH   = NUM_LANES * (2 ** HEAD_W);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_THRESHOLD = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_THRESHOLD = CSR_INDEX_W'(1);

   localparam logic [SIZE_THR_W-1:0] SIZE_THR_RESET = SIZE_THR_W'(5);
   localparam logic [WAIT_THR_W-1:0] WAIT_THR_RESET = WAIT_THR_W'(20);
   localparam logic [LANE_W-1:0]     START_LANE     = LANE_W'(3);
   localparam logic [ID_W-1:0]       FIRST_ID       = ID_W'(1);

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_SERVE   = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ENQUEUED = 2'd0,
      STATUS_DROPPED  = 2'd1,
      STATUS_SERVED   = 2'd2,
      STATUS_IDLE     = 2'd3
   } rsp_status_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] arrival;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic calc;
      logic pick;
      logic commit_arrival;
      logic commit_serve;
      logic fill;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
      logic refill;
   } dp_status_type;

endpackage

`default_nettype wire

>>> src/fpa_channels.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on fpa_pkg for field widths.
`default_nettype none

interface fpa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [fpa_pkg::LANE_W-1:0]  lane;
   logic [fpa_pkg::TIME_W-1:0]  now_time;

   modport source (output valid, output operation, output lane, output now_time,
                   input ready);
   modport sink   (input valid, input operation, input lane, input now_time,
                   output ready);
endinterface

interface fpa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [fpa_pkg::LANE_W-1:0]  served_lane;
   logic [fpa_pkg::ID_W-1:0]    entry_id;
   logic [fpa_pkg::TIME_W-1:0]  wait_time;
   logic                        honk;

   modport source (output valid, output status, output served_lane, output entry_id,
                   output wait_time, output honk, input ready);
   modport sink   (input valid, input status, input served_lane, input entry_id,
                   input wait_time, input honk, output ready);
endinterface

`default_nettype wire

>>> src/fpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]              read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

>>> src/fpa_ctrl.sv
// Sequencing state machine for the arbiter: issues datapath commands per item.
// Depends on fpa_pkg.
`default_nettype none

module fpa_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_accept,
   input  wire logic                   req_is_serve,
   input  wire fpa_pkg::dp_status_type status,
   output fpa_pkg::dp_cmd_type         cmd,
   output logic                        req_ready
);
   import fpa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_CALC,
      ST_PICK,
      ST_DECIDE,
      ST_FILL
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_accept;
            if (req_accept) begin
               state_in = req_is_serve ? ST_CALC : ST_ARRIVE;
               ready_in = 1'b0;
            end
         end
         ST_ARRIVE: begin
            cmd.commit_arrival = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.commit_serve = status.out_free;
            if (status.out_free) begin
               if (status.refill) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_IDLE;
                  ready_in = 1'b1;
               end
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

>>> src/fpa_datapath.sv
// Lane queues, front-entry cache, lane selection and response register.
// Depends on fpa_pkg, fpa_channels (response interface) and fpa_ram.
`default_nettype none

module fpa_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire fpa_pkg::dp_cmd_type                cmd,
   output fpa_pkg::dp_status_type                  status,
   input  wire logic [fpa_pkg::LANE_W-1:0]         req_lane,
   input  wire logic [fpa_pkg::TIME_W-1:0]         req_now_time,
   input  wire logic [fpa_pkg::SIZE_THR_W-1:0]     size_threshold,
   input  wire logic [fpa_pkg::WAIT_THR_W-1:0]     wait_threshold,
   fpa_rsp_if.source                               rsp_channel
);
   import fpa_pkg::*;

   // Index of the largest of four values, ties to the highest index.
   function automatic logic [LANE_W-1:0] pick_max_index(input logic [PICK_W-1:0] v [NUM_LANES]);
      logic [LANE_W-1:0] lo;
      logic [LANE_W-1:0] hi;
      lo = (v[1] >= v[0]) ? LANE_W'(1) : LANE_W'(0);
      hi = (v[3] >= v[2]) ? LANE_W'(3) : LANE_W'(2);
      return (v[hi] >= v[lo]) ? hi : lo;
   endfunction

   // Captured request
   logic [LANE_W-1:0]   lane_ff, lane_in;
   logic [TIME_W-1:0]   now_ff, now_in;

   // Queue state
   logic [HEAD_W-1:0]   head_ff [NUM_LANES];
   logic [HEAD_W-1:0]   head_in [NUM_LANES];
   logic [COUNT_W-1:0]  count_ff [NUM_LANES];
   logic [COUNT_W-1:0]  count_in [NUM_LANES];
   logic [ID_W-1:0]     front_id_ff [NUM_LANES];
   logic [ID_W-1:0]     front_id_in [NUM_LANES];
   logic [TIME_W-1:0]   front_time_ff [NUM_LANES];
   logic [TIME_W-1:0]   front_time_in [NUM_LANES];
   logic [LANE_W-1:0]   current_lane_ff, current_lane_in;
   logic [ID_W-1:0]     next_id_ff, next_id_in;
   logic                idle_flag_ff, idle_flag_in;

   // Selection pipeline
   logic [PICK_W-1:0]   wait_ff [NUM_LANES];
   logic [PICK_W-1:0]   wait_in [NUM_LANES];
   logic [PICK_W-1:0]   count_ext [NUM_LANES];
   logic [LANE_W-1:0]   size_idx_ff, size_idx_in;
   logic [COUNT_W-1:0]  size_max_ff, size_max_in;
   logic [LANE_W-1:0]   wait_idx_ff, wait_idx_in;
   logic [PICK_W-1:0]   wait_max_ff, wait_max_in;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_status_type      rsp_status_ff, rsp_status_in;
   logic [LANE_W-1:0]   rsp_lane_ff, rsp_lane_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [TIME_W-1:0]   rsp_wait_ff, rsp_wait_in;
   logic                rsp_honk_ff, rsp_honk_in;

   // Arrival path
   logic [COUNT_W-1:0]  arr_count;
   logic                arr_full;
   logic [HEAD_W:0]     tail_sum;
   logic [HEAD_W-1:0]   tail;

   // Serve path
   logic                size_hit;
   logic                wait_hit;
   logic [LANE_W-1:0]   chosen;
   logic [COUNT_W-1:0]  chosen_count;
   logic                chosen_empty;
   logic [HEAD_W:0]     head_sum;
   logic [HEAD_W-1:0]   head_next;
   logic                refill;
   logic                all_empty;

   // Entry memory
   logic                ram_write_enable;
   logic [ADDR_W-1:0]   ram_write_address;
   entry_type           ram_write_data;
   logic                ram_read_enable;
   logic [ADDR_W-1:0]   ram_read_address;
   entry_type           ram_read_data;

   fpa_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (RAM_DEPTH)
   ) u_entry_ram (
      .clock         (clock),
      .write_enable  (ram_write_enable),
      .write_address (ram_write_address),
      .write_data    (ram_write_data),
      .read_enable   (ram_read_enable),
      .read_address  (ram_read_address),
      .read_data     (ram_read_data)
   );

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         count_ext[i] = PICK_W'(count_ff[i]);
      end
   end

   // Arrival: slot behind the last entry, wrapped into the lane's ring
   assign arr_count = count_ff[lane_ff];
   assign arr_full  = (arr_count == COUNT_W'(QUEUE_DEPTH));
   assign tail_sum  = (HEAD_W+1)'(head_ff[lane_ff]) + (HEAD_W+1)'(arr_count);
   assign tail      = (tail_sum >= (HEAD_W+1)'(QUEUE_DEPTH))
                      ? HEAD_W'(tail_sum - (HEAD_W+1)'(QUEUE_DEPTH))
                      : HEAD_W'(tail_sum);

   // Serve: threshold rules, then keep current unless it ran dry
   assign size_hit = (CMP_W'(size_max_ff) >= CMP_W'(size_threshold));
   assign wait_hit = (wait_max_ff >= PICK_W'(wait_threshold));

   always_comb begin
      if (size_hit) begin
         chosen = size_idx_ff;
      end else if (wait_hit) begin
         chosen = wait_idx_ff;
      end else if (count_ff[current_lane_ff] == '0) begin
         chosen = size_idx_ff;
      end else begin
         chosen = current_lane_ff;
      end
   end

   assign chosen_count = count_ff[chosen];
   assign chosen_empty = (chosen_count == '0);
   assign head_sum     = (HEAD_W+1)'(head_ff[chosen]) + (HEAD_W+1)'(1);
   assign head_next    = (head_sum == (HEAD_W+1)'(QUEUE_DEPTH)) ? '0 : HEAD_W'(head_sum);
   assign refill       = (chosen_count > COUNT_W'(1));
   assign all_empty    = (count_ff[0] == '0) && (count_ff[1] == '0)
                         && (count_ff[2] == '0) && (count_ff[3] == '0);

   assign ram_write_enable    = cmd.commit_arrival && !arr_full;
   assign ram_write_address   = {lane_ff, tail};
   assign ram_write_data.id      = next_id_ff;
   assign ram_write_data.arrival = now_ff;
   assign ram_read_enable     = cmd.commit_serve && refill;
   assign ram_read_address    = {chosen, head_next};

   assign status.out_free = !rsp_valid_ff || rsp_channel.ready;
   assign status.refill   = refill;

   always_comb begin
      lane_in         = lane_ff;
      now_in          = now_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      front_id_in     = front_id_ff;
      front_time_in   = front_time_ff;
      current_lane_in = current_lane_ff;
      next_id_in      = next_id_ff;
      idle_flag_in    = idle_flag_ff;
      wait_in         = wait_ff;
      size_idx_in     = size_idx_ff;
      size_max_in     = size_max_ff;
      wait_idx_in     = wait_idx_ff;
      wait_max_in     = wait_max_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_channel.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_lane_in     = rsp_lane_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_wait_in     = rsp_wait_ff;
      rsp_honk_in     = rsp_honk_ff;

      if (cmd.capture) begin
         lane_in = req_lane;
         now_in  = req_now_time;
      end

      // Empty lanes count as zero wait
      if (cmd.calc) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            wait_in[i] = (count_ff[i] == '0) ? '0 : PICK_W'(now_ff - front_time_ff[i]);
         end
      end

      if (cmd.pick) begin
         size_idx_in = pick_max_index(count_ext);
         size_max_in = count_ff[size_idx_in];
         wait_idx_in = pick_max_index(wait_ff);
         wait_max_in = wait_ff[wait_idx_in];
      end

      if (cmd.commit_arrival) begin
         if (!arr_full) begin
            count_in[lane_ff] = arr_count + COUNT_W'(1);
            if (arr_count == '0) begin
               front_id_in[lane_ff]   = next_id_ff;
               front_time_in[lane_ff] = now_ff;
            end
         end
         next_id_in    = next_id_ff + ID_W'(1);
         idle_flag_in  = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_status_in = arr_full ? STATUS_DROPPED : STATUS_ENQUEUED;
         rsp_lane_in   = lane_ff;
         rsp_id_in     = next_id_ff;
         rsp_wait_in   = '0;
         rsp_honk_in   = idle_flag_ff;
      end

      if (cmd.commit_serve) begin
         current_lane_in = chosen;
         rsp_valid_in    = 1'b1;
         rsp_lane_in     = chosen;
         rsp_honk_in     = 1'b0;
         if (chosen_empty) begin
            idle_flag_in  = 1'b1;
            rsp_status_in = STATUS_IDLE;
            rsp_id_in     = '0;
            rsp_wait_in   = '0;
         end else begin
            rsp_status_in    = STATUS_SERVED;
            rsp_id_in        = front_id_ff[chosen];
            rsp_wait_in      = TIME_W'(wait_ff[chosen]);
            head_in[chosen]  = head_next;
            count_in[chosen] = chosen_count - COUNT_W'(1);
         end
      end

      // New front of the lane just served
      if (cmd.fill) begin
         front_id_in[current_lane_ff]   = ram_read_data.id;
         front_time_in[current_lane_ff] = ram_read_data.arrival;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         current_lane_ff <= START_LANE;
         next_id_ff      <= FIRST_ID;
         idle_flag_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         head_ff         <= head_in;
         count_ff        <= count_in;
         current_lane_ff <= current_lane_in;
         next_id_ff      <= next_id_in;
         idle_flag_ff    <= idle_flag_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff       <= lane_in;
      now_ff        <= now_in;
      front_id_ff   <= front_id_in;
      front_time_ff <= front_time_in;
      wait_ff       <= wait_in;
      size_idx_ff   <= size_idx_in;
      size_max_ff   <= size_max_in;
      wait_idx_ff   <= wait_idx_in;
      wait_max_ff   <= wait_max_in;
      rsp_status_ff <= rsp_status_in;
      rsp_lane_ff   <= rsp_lane_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_honk_ff   <= rsp_honk_in;
   end

   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.status      = rsp_status_ff;
   assign rsp_channel.served_lane = rsp_lane_ff;
   assign rsp_channel.entry_id    = rsp_id_ff;
   assign rsp_channel.wait_time   = rsp_wait_ff;
   assign rsp_channel.honk        = rsp_honk_ff;

   // A commit must never overwrite a response still waiting for transfer
   commit_needs_free_out: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_arrival || cmd.commit_serve) |-> (!rsp_valid_ff || rsp_channel.ready))
      else $error("commit while response register occupied");

   lane_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (count_ff[0] <= COUNT_W'(QUEUE_DEPTH)) && (count_ff[1] <= COUNT_W'(QUEUE_DEPTH))
      && (count_ff[2] <= COUNT_W'(QUEUE_DEPTH)) && (count_ff[3] <= COUNT_W'(QUEUE_DEPTH)))
      else $error("lane count above queue depth");

   fill_follows_serve: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> $past(cmd.commit_serve && refill))
      else $error("front refill without a preceding serve");

   empty_serve_reports_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_serve && all_empty) |=> (rsp_valid_ff && rsp_status_ff == STATUS_IDLE
                                            && idle_flag_ff))
      else $error("serve with all lanes empty did not report idle");

endmodule

`default_nettype wire

>>> src/four_lane_priority_arbiter.sv
// Top level of the four-lane priority arbiter: CSR registers and block wiring.
// Depends on fpa_pkg, fpa_channels, fpa_ctrl, fpa_datapath (and fpa_ram below it).
//
//   Port group    Dir   Payload                                        Transfer when
//   req_channel   in    operation, lane, now_time                      valid && ready
//   rsp_channel   out   status, served_lane, entry_id, wait_time, honk valid && ready
//   csr_*         in    csr_index, csr_write_data                      csr_write_enable
//
// An arrival occupies the block for its accept and then its commit to the queue.
// A serve passes through accept, wait compute, max pick and commit, plus a fill
// step when the served lane still holds entries: its new front entry comes back from
// the entry RAM through its registered read port into the per-lane front cache.
// Synchronous active-high reset; the entry RAM needs no clearing pass, so a
// request can be accepted as soon as reset is released. A result sits in the
// response register while the next request is accepted; a commit stalls only
// while that register is still full and not being drained.
`default_nettype none

module four_lane_priority_arbiter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   fpa_req_if.sink                                req_channel,
   fpa_rsp_if.source                              rsp_channel,
   input  wire logic                              csr_write_enable,
   input  wire logic [fpa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [fpa_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import fpa_pkg::*;

   // Threshold registers
   logic [SIZE_THR_W-1:0] size_thr_ff, size_thr_in;
   logic [WAIT_THR_W-1:0] wait_thr_ff, wait_thr_in;

   dp_cmd_type    cmd;
   dp_status_type dp_status;
   logic          req_ready;
   logic          req_accept;
   logic          req_is_serve;

   // Decode the write; upper data bits beyond a register's width are dropped
   always_comb begin
      size_thr_in = size_thr_ff;
      wait_thr_in = wait_thr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SIZE_THRESHOLD: size_thr_in = csr_write_data[SIZE_THR_W-1:0];
            CSR_WAIT_THRESHOLD: wait_thr_in = csr_write_data[WAIT_THR_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_thr_ff <= SIZE_THR_RESET;
         wait_thr_ff <= WAIT_THR_RESET;
      end else begin
         size_thr_ff <= size_thr_in;
         wait_thr_ff <= wait_thr_in;
      end
   end

   // Request handshake: the controller owns ready, the datapath takes the payload
   assign req_channel.ready = req_ready;
   assign req_accept        = req_channel.valid && req_ready;
   assign req_is_serve      = (req_channel.operation == OP_SERVE);

   fpa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .req_is_serve (req_is_serve),
      .status       (dp_status),
      .cmd          (cmd),
      .req_ready    (req_ready)
   );

   fpa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (dp_status),
      .req_lane       (req_channel.lane),
      .req_now_time   (req_channel.now_time),
      .size_threshold (size_thr_ff),
      .wait_threshold (wait_thr_ff),
      .rsp_channel    (rsp_channel)
   );

endmodule

`default_nettype wire

>>> dv/fpa_grant_checker.sv
// Checker for the four-lane priority arbiter: watches request, response and CSR traffic,
// predicts every grant and compares it field by field with the block's response.
// Depends on fpa_pkg and the channel interfaces in fpa_channels.
module fpa_grant_checker (
   input  logic                            clock,
   input  logic                            reset,
   fpa_req_if                              req_mon,
   fpa_rsp_if                              rsp_mon,
   input  logic                            csr_write_enable,
   input  logic [fpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpa_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int unsigned                     mismatch_count,
   output int unsigned                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import fpa_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      rsp_status_type    status;
      logic [LANE_W-1:0] lane;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] waited;
      logic              honk;
   } grant_type;

   grant_type awaited_grants[$];
   grant_type want;

   // Shadow copy of the lane queues and arbitration state
   logic [ID_W-1:0]       slot_id      [NUM_LANES][QUEUE_DEPTH];
   logic [TIME_W-1:0]     slot_arrival [NUM_LANES][QUEUE_DEPTH];
   logic [HEAD_W-1:0]     lane_front   [NUM_LANES];
   int unsigned           lane_fill    [NUM_LANES];
   logic [LANE_W-1:0]     active_lane;
   logic [ID_W-1:0]       id_counter;
   logic                  was_idle;
   logic [SIZE_THR_W-1:0] size_limit;
   logic [WAIT_THR_W-1:0] wait_limit;

   function automatic grant_type arbitrate(input logic op, input logic [LANE_W-1:0] ln,
                                           input logic [TIME_W-1:0] now);
      grant_type         g;
      logic [TIME_W-1:0] waited [NUM_LANES];
      int unsigned       fill_max, wait_max, fill_pick, wait_pick, pick;
      logic [HEAD_W-1:0] tail;
      g = '0;
      if (op == OP_ARRIVAL) begin
         g.lane = ln;
         g.id   = id_counter;
         g.honk = was_idle;
         if (lane_fill[ln] < QUEUE_DEPTH) begin
            tail = lane_front[ln] + HEAD_W'(lane_fill[ln]);
            slot_id[ln][tail]      = id_counter;
            slot_arrival[ln][tail] = now;
            lane_fill[ln]++;
            g.status = STATUS_ENQUEUED;
         end else begin
            g.status = STATUS_DROPPED;
         end
         id_counter++;
         was_idle = 1'b0;
         return g;
      end
      // Serve: fullest, then oldest, at limit; else stay if filled (ties to top lane)
      fill_max  = 0;
      wait_max  = 0;
      fill_pick = 0;
      wait_pick = 0;
      for (int i = 0; i < NUM_LANES; i++) begin
         waited[i] = (lane_fill[i] == 0) ? '0 : now - slot_arrival[i][lane_front[i]];
         if (lane_fill[i] >= fill_max) begin
            fill_max  = lane_fill[i];
            fill_pick = i;
         end
         if (waited[i] >= wait_max) begin
            wait_max  = waited[i];
            wait_pick = i;
         end
      end
      if (fill_max >= size_limit)
         pick = fill_pick;
      else if (wait_max >= wait_limit)
         pick = wait_pick;
      else if (lane_fill[active_lane] == 0)
         pick = fill_pick;
      else
         pick = active_lane;
      active_lane = LANE_W'(pick);
      g.lane      = active_lane;
      if (lane_fill[pick] == 0) begin
         g.status = STATUS_IDLE;
         was_idle = 1'b1;
      end else begin
         g.status = STATUS_SERVED;
         g.id     = slot_id[pick][lane_front[pick]];
         g.waited = now - slot_arrival[pick][lane_front[pick]];
         lane_front[pick]++;
         lane_fill[pick]--;
      end
      return g;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         awaited_grants.delete();
         for (int i = 0; i < NUM_LANES; i++) begin
            lane_front[i] = '0;
            lane_fill[i]  = 0;
         end
         active_lane    = START_LANE;
         id_counter     = FIRST_ID;
         was_idle       = 1'b0;
         size_limit     = SIZE_THR_RESET;
         wait_limit     = WAIT_THR_RESET;
         mismatch_count = 0;
      end else begin
         if (csr_write_enable === 1'b1) begin
            if (csr_index == CSR_SIZE_THRESHOLD)
               size_limit = csr_write_data[SIZE_THR_W-1:0];
            else if (csr_index == CSR_WAIT_THRESHOLD)
               wait_limit = csr_write_data[WAIT_THR_W-1:0];
         end
         // Retire the response first so it can never match a request of this edge
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (awaited_grants.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: response with no request pending: status %0d lane %0d id %0h",
                           $time, rsp_mon.status, rsp_mon.served_lane, rsp_mon.entry_id);
            end else begin
               want = awaited_grants.pop_front();
               if (rsp_mon.status !== want.status || rsp_mon.served_lane !== want.lane ||
                   rsp_mon.entry_id !== want.id || rsp_mon.wait_time !== want.waited ||
                   rsp_mon.honk !== want.honk) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: expected status %0d lane %0d id %0h wait %0h honk %0b",
                              $time, want.status, want.lane, want.id, want.waited,
                              want.honk);
                     $display("%0t:      got status %0d lane %0d id %0h wait %0h honk %0b",
                              $time, rsp_mon.status, rsp_mon.served_lane,
                              rsp_mon.entry_id, rsp_mon.wait_time, rsp_mon.honk);
                  end
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            awaited_grants.push_back(arbitrate(req_mon.operation, req_mon.lane,
                                               req_mon.now_time));
      end
      outstanding = awaited_grants.size();
   end

endmodule

>>> dv/tb_four_lane_priority_arbiter.sv
// Top of the four-lane priority arbiter testbench: clock, reset, stimulus and verdict.
// Depends on fpa_pkg, fpa_channels, the block itself and fpa_grant_checker.
module tb_four_lane_priority_arbiter;
   timeunit 1ns;
   timeprecision 1ps;
   import fpa_pkg::*;

   // Hard stop well above the slowest legal run; leave ample margin
   localparam int unsigned CYCLE_LIMIT  = 1_500_000;
   // Let a serve finish its front-cache refill before touching the registers
   localparam int unsigned SETTLE_DELAY = 8;
   localparam int unsigned PHASE_ITEMS  = 175;
   localparam int unsigned NUM_PHASES   = 6;

   localparam logic [SIZE_THR_W-1:0] SIZE_PLAN [NUM_PHASES] = '{
      11'd5, 11'd2, 11'd0, 11'd2047, 11'd3, 11'd4};
   localparam logic [WAIT_THR_W-1:0] WAIT_PLAN [NUM_PHASES] = '{
      32'd20, 32'd8, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd30};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int unsigned            mismatch_count;
   int unsigned            outstanding;
   int unsigned            cycle_count = 0;
   logic                   steady;   // high: neither side idles
   logic [TIME_W-1:0]      tick;     // running timestamp for arrivals and serves

   fpa_req_if req_bus();
   fpa_rsp_if rsp_bus();

   four_lane_priority_arbiter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   fpa_grant_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Hard stop: a lost response or a hung handshake ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one; none while steady
   function automatic int unsigned idle_cycles();
      int unsigned r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Advance time in small steps so waits land near the thresholds; jump rarely
   // so every timestamp bit toggles and waits wrap through zero
   function automatic logic [TIME_W-1:0] next_tick();
      int unsigned r;
      r = $urandom_range(0, 49);
      if (r == 0)
         tick = $urandom;
      else if (r < 3)
         tick = tick + $urandom_range(20, 200);
      else
         tick = tick + $urandom_range(0, 5);
      return tick;
   endfunction

   // Present one request, hold it until the transfer, then maybe drop valid for a gap.
   // Valid is only lowered at the step after a transfer, so a back-to-back request
   // never sees valid lowered and raised in the same step.
   task automatic offer(input logic op, input logic [LANE_W-1:0] ln,
                        input logic [TIME_W-1:0] now);
      int unsigned gap;
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.lane      <= ln;
      req_bus.now_time  <= now;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      @(negedge clock);
      gap = idle_cycles();
      if (gap != 0) begin
         req_bus.valid     <= 1'b0;
         req_bus.operation <= 1'($urandom_range(0, 1));
         req_bus.lane      <= LANE_W'($urandom_range(0, 3));
         req_bus.now_time  <= $urandom;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid, wait for every grant to come back, then let the block settle
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_DELAY) @(negedge clock);
   endtask

   // Write both thresholds on consecutive edges; junk in the unused size bits
   task automatic program_thresholds(input logic [SIZE_THR_W-1:0] size_thr,
                                     input logic [WAIT_THR_W-1:0] wait_thr);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SIZE_THRESHOLD;
      csr_write_data   <= {junk[CSR_DATA_W-1:SIZE_THR_W], size_thr};
      @(negedge clock);
      csr_index        <= CSR_WAIT_THRESHOLD;
      csr_write_data   <= wait_thr;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= $urandom;
   endtask

   // Random arrivals and serves, with one lane favored so fill levels drift apart
   task automatic random_traffic(input int unsigned items, input int unsigned arrival_pct);
      logic [LANE_W-1:0] favored;
      logic [LANE_W-1:0] ln;
      logic              op;
      favored = LANE_W'($urandom_range(0, 3));
      for (int unsigned n = 0; n < items; n++) begin
         // Reroll now and then so long stretches without idling appear
         if (n % 40 == 0)
            steady = ($urandom_range(0, 3) == 0);
         op = ($urandom_range(0, 99) < arrival_pct) ? OP_ARRIVAL : OP_SERVE;
         ln = ($urandom_range(0, 2) == 0) ? favored : LANE_W'($urandom_range(0, 3));
         offer(op, ln, next_tick());
      end
   endtask

   // Response side: ready high for a while, then stall for a random gap
   initial begin
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         int unsigned stall;
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         stall = idle_cycles();
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_SIZE_THRESHOLD;
      csr_write_data    = '0;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_ARRIVAL;
      req_bus.lane      = '0;
      req_bus.now_time  = '0;
      steady            = 1'b0;
      tick              = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset thresholds (size 5, wait 20), current lane 3
      offer(OP_SERVE, 2'd0, 32'd100);          // all lanes empty: idle, ties go to lane 3
      offer(OP_SERVE, 2'd1, 32'd101);          // idle while already idle
      offer(OP_ARRIVAL, 2'd0, 32'd0);          // first arrival after idle honks
      offer(OP_ARRIVAL, 2'd1, 32'hFFFF_FFFF);
      offer(OP_ARRIVAL, 2'd2, 32'd5);
      offer(OP_ARRIVAL, 2'd3, 32'd7);
      offer(OP_SERVE, 2'd2, 32'd10);           // below both thresholds: stay on lane 3
      offer(OP_SERVE, 2'd3, 32'd30);           // oldest front wins, wait wraps past zero
      for (int unsigned t = 31; t < 35; t++)
         offer(OP_ARRIVAL, 2'd0, t);
      offer(OP_SERVE, 2'd0, 32'd35);           // lane 0 reaches the size threshold

      // Size threshold zero: always the fullest lane; drain into idle
      quiesce();
      program_thresholds(11'd0, 32'd0);
      repeat (6) offer(OP_SERVE, 2'd0, 32'd40);

      // Wait threshold zero with zero waits: the chosen lane is empty
      quiesce();
      program_thresholds(11'h7FF, 32'd0);
      offer(OP_ARRIVAL, 2'd0, 32'd500);
      offer(OP_SERVE, 2'd0, 32'd500);
      offer(OP_ARRIVAL, 2'd0, 32'd501);
      offer(OP_SERVE, 2'd0, 32'd600);
      offer(OP_SERVE, 2'd0, 32'd600);

      // Largest thresholds: only an all-ones wait qualifies, otherwise stay put unless the current lane is empty
      quiesce();
      program_thresholds(11'd2047, 32'hFFFF_FFFF);
      offer(OP_ARRIVAL, 2'd1, 32'd1);
      offer(OP_ARRIVAL, 2'd2, 32'd0);
      offer(OP_SERVE, 2'd0, 32'd0);            // lane 1 front waits exactly all-ones
      offer(OP_SERVE, 2'd0, 32'd0);            // current lane empty: fullest lane
      offer(OP_ARRIVAL, 2'd2, 32'd0);
      offer(OP_ARRIVAL, 2'd3, 32'd0);
      offer(OP_SERVE, 2'd0, 32'd2);            // hold lane 2 over the higher lane 3

      // Random phases, one threshold setting each; one starts just short of the time wrap
      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         quiesce();
         if (p == NUM_PHASES - 1)
            program_thresholds(SIZE_THR_W'($urandom_range(1, 6)),
                               WAIT_THR_W'($urandom_range(5, 60)));
         else
            program_thresholds(SIZE_PLAN[p], WAIT_PLAN[p]);
         if (p == 2)
            tick = 32'hFFFF_FF80;
         random_traffic(PHASE_ITEMS, (p == 3) ? 50 : 55);
      end

      // Wait out every grant, then the block's own latency
      steady = 1'b0;
      quiesce();
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
